[hw/rtl/rgb_convolution_3x3_core_assert.svh]
// ----------------------------------------------------------------------------
// RGB 3x3 convolution core - assertion macros
// Shorthands for concurrent assertions clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RGB_CONVOLUTION_3X3_CORE_ASSERT_SVH
`define RGB_CONVOLUTION_3X3_CORE_ASSERT_SVH

// Generic property check on clk_i, quiet while rst_ni is low
`define RGBC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Signal must hold its value in the cycle after cond
`define RGBC_ASSERT_HOLD(name, cond, sig, msg) \
  `RGBC_ASSERT(name, (cond) |=> $stable(sig), msg)

`endif

[hw/rtl/rgbc_pkg.sv]
// ----------------------------------------------------------------------------
// RGB 3x3 convolution - shared package
// Widths, register indexes, pipeline control types and arithmetic constants.
// ----------------------------------------------------------------------------
package rgbc_pkg;

  // Geometry
  localparam int DefMaxWidth = 4096;
  localparam int MaxHeight   = 4096;
  localparam int GeomW       = 13;   // width of the geometry registers
  localparam int RowW        = 12;   // row counter (rows < MaxHeight)
  localparam int ResetWidth  = 640;
  localparam int ResetHeight = 480;

  // Pixel and coefficient layout
  localparam int ChanW    = 8;
  localparam int NumChan  = 3;
  localparam int PixW     = ChanW * NumChan;
  localparam int CoefW    = 24;      // three signed 8-bit weights per column
  localparam int WeightW  = 8;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 24;

  // Pipeline
  localparam int LaneLat  = 4;       // register stages inside one lane
  localparam int OutDepth = 8;       // result buffer entries (power of two)

  // Divide by 9, double, clamp to 0..254:
  // sums at or above 127*9 saturate; below that q = (acc * 3641) >> 15 is exact.
  localparam int SatThresh = 1143;
  localparam int SatValue  = 254;
  localparam int DivRecip  = 3641;
  localparam int DivShift  = 15;

  // Request kind carried on tuser
  localparam logic CmdFlush = 1'b1;

  typedef logic [PixW-1:0]  pixel_t;
  typedef logic [ChanW-1:0] chan_t;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_WIDTH      = 3'd0,
    CFG_HEIGHT     = 3'd1,
    CFG_COEF_LEFT  = 3'd2,
    CFG_COEF_MID   = 3'd3,
    CFG_COEF_RIGHT = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_CALC,     // interior pixel, filtered
    KIND_CENTER,   // border pixel emitted on a pixel request
    KIND_FLUSH     // border pixel drained by a flush request
  } emit_kind_e;

  // Control that leaves the accept stage
  typedef struct packed {
    logic       valid;   // a result follows
    emit_kind_e kind;
    logic       last;    // last pixel of the frame
    logic       step;    // a pixel was stored, shift the window
  } s1_ctrl_t;

  // Control that travels beside the lanes
  typedef struct packed {
    logic valid;
    logic calc;
    logic last;
  } res_ctrl_t;

endpackage

[hw/rtl/rgbc_line_store.sv]
// ----------------------------------------------------------------------------
// RGB 3x3 convolution - line store
// Ring of recent pixels: one write port, two registered read ports.
// Reads return the old contents when they hit the address being written.
// ----------------------------------------------------------------------------
module rgbc_line_store
  import rgbc_pkg::*;
#(
  parameter int AW = 13
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  pixel_t        wdata_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output pixel_t        rdata_a_o,
  output pixel_t        rdata_b_o
);

  pixel_t mem [2**AW];

  // Read-first ring memory
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

endmodule

[hw/rtl/rgbc_lane.sv]
// ----------------------------------------------------------------------------
// RGB 3x3 convolution - channel lane
// Nine signed products, column sums, total, then divide by 9, double and clamp.
// Four register stages from window to result.
// ----------------------------------------------------------------------------
module rgbc_lane
  import rgbc_pkg::*;
(
  input  logic                        clk_i,
  input  logic [2:0][2:0][ChanW-1:0]  win_i,    // [column][row], row 0 on top
  input  logic [2:0][CoefW-1:0]       coef_i,   // [column], row -1 in low byte
  output chan_t                       res_o
);

  localparam int ProdW = ChanW + 1 + WeightW;
  localparam int ColW  = ProdW + 2;
  localparam int AccW  = ColW + 2;
  localparam int QInW  = $clog2(SatThresh);
  localparam int RecW  = $clog2(DivRecip + 1);
  localparam int QW    = QInW + RecW;
  localparam int OutQW = ChanW - 1;

  logic signed [ProdW-1:0] prod_q [3][3];
  logic signed [ColW-1:0]  col_q  [3];
  logic signed [AccW-1:0]  acc_q;
  logic        [QW-1:0]    quot;
  chan_t                   res_d;

  // Stage 1: products, pixel taken as unsigned
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        prod_q[c][r] <= $signed({1'b0, win_i[c][r]}) *
                        $signed(coef_i[c][WeightW*r +: WeightW]);
      end
    end
  end

  // Stage 2: column sums
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      col_q[c] <= ColW'(prod_q[c][0]) + ColW'(prod_q[c][1]) + ColW'(prod_q[c][2]);
    end
  end

  // Stage 3: total
  always_ff @(posedge clk_i) begin
    acc_q <= AccW'(col_q[0]) + AccW'(col_q[1]) + AccW'(col_q[2]);
  end

  // Stage 4: scale and clamp; negative sums give zero
  always_comb begin
    quot = QW'(acc_q[QInW-1:0]) * QW'(DivRecip);
    if (acc_q[AccW-1]) begin
      res_d = '0;
    end else if (acc_q >= $signed(AccW'(SatThresh))) begin
      res_d = ChanW'(SatValue);
    end else begin
      res_d = {quot[DivShift +: OutQW], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    res_o <= res_d;
  end

endmodule

[hw/rtl/rgbc_merge.sv]
// ----------------------------------------------------------------------------
// RGB 3x3 convolution - merge and result buffer
// Joins the three lane results or the passed pixel into one result and
// queues it for the output stream.
// ----------------------------------------------------------------------------
module rgbc_merge
  import rgbc_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  res_ctrl_t                  ctrl_i,
  input  pixel_t                     pass_i,
  input  logic [NumChan-1:0][ChanW-1:0] lane_i,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [PixW-1:0]            m_axis_tdata,
  output logic                       m_axis_tlast
);

  localparam int PtrW = $clog2(OutDepth);

  typedef struct packed {
    logic   last;
    pixel_t pix;
  } entry_t;

  entry_t            slot_q [OutDepth];
  entry_t            entry;
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [PtrW:0]     fill_q;
  logic              push, pop;

  // Pick filtered or passed pixel
  always_comb begin
    entry.last = ctrl_i.last;
    entry.pix  = ctrl_i.calc ? pixel_t'(lane_i) : pass_i;
  end

  assign push = ctrl_i.valid;
  assign pop  = m_axis_tvalid & m_axis_tready;

  // Buffer storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= entry;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      fill_q <= fill_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  assign m_axis_tvalid = (fill_q != '0);
  assign m_axis_tdata  = slot_q[rd_q].pix;
  assign m_axis_tlast  = slot_q[rd_q].last;

endmodule

[hw/rtl/rgb_convolution_3x3_core.sv]
// ----------------------------------------------------------------------------
// RGB 3x3 convolution core
// Streaming 3x3 filter over RGB pixels in raster order. Interior pixels get a
// weighted sum per channel, divided by 9, doubled and clamped to 0..254;
// the border ring passes through. Three channel lanes run side by side.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake                    Payload
//  s_axis    in   s_axis_tvalid/tready         tdata: red, green, blue; tuser: cmd
//  m_axis    out  m_axis_tvalid/tready         tdata: red, green, blue; tlast: frame_end
//  cfg       in   cfg_we_i (no wait)           cfg_addr_i, cfg_wdata_i
//
//  One request per clock while s_axis_tready is high. A result passes the accept
//  stage, line store read, window and four lane stages, then the result buffer.
//  Up to 8 results may be outstanding; s_axis_tready drops while all 8 are
//  held, set by the depth of the result buffer.
//  Reset clears counters, window and buffer; the line store is not cleared
//  and needs no clearing pass, since only pixels stored since the last
//  restart are read.
// ----------------------------------------------------------------------------
module rgb_convolution_3x3_core
  import rgbc_pkg::*;
#(
  parameter int MAX_WIDTH = DefMaxWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input pixel stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [PixW-1:0]     s_axis_tdata,   // [7:0] red_in, [15:8] green_in, [23:16] blue_in
  input  logic                s_axis_tuser,   // [0] cmd
  // Output pixel stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [PixW-1:0]     m_axis_tdata,   // [7:0] red_out, [15:8] green_out, [23:16] blue_out
  output logic                m_axis_tlast,   // frame_end
  // Configuration
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int CB      = $clog2(MAX_WIDTH);
  localparam int PB      = $clog2(MAX_WIDTH + 2);
  localparam int AW      = $clog2(2 * MAX_WIDTH);
  localparam int CreditW = $clog2(OutDepth + 1);
  localparam int CtrlLat = LaneLat + 1;
  localparam int ResetW  = (ResetWidth > MAX_WIDTH) ? MAX_WIDTH : ResetWidth;

  localparam logic [GeomW:0]   MinGeomW = (GeomW+1)'(3);
  localparam logic [GeomW:0]   MaxGeomW = (GeomW+1)'(MAX_WIDTH);
  localparam logic [GeomW-1:0] MinGeomH = GeomW'(3);
  localparam logic [GeomW-1:0] MaxGeomH = GeomW'(MaxHeight);

  // Configuration
  logic [WW-1:0]               eff_w_q, eff_w_d;
  logic [GeomW-1:0]            eff_h_q, eff_h_d;
  logic [2:0][CoefW-1:0]       coef_q;
  logic [GeomW:0]              w_raw;
  logic [GeomW-1:0]            h_raw;
  logic                        geom_wr;

  // Accept stage
  logic                        acc_in, is_pix, pop;
  logic [PB-1:0]               pending_q, pending_d, pend_full;
  logic [CB-1:0]               out_col_q, out_col_d;
  logic [RowW-1:0]             out_row_q, out_row_d;
  logic [AW-1:0]               wr_ptr_q, raddr_a, raddr_b;
  logic [CreditW-1:0]          credit_q;
  logic                        col_last, row_last, border, emit;
  s1_ctrl_t                    s1_d, s1_q;
  pixel_t                      s1_pix_q;
  pixel_t                      rd_a, rd_b;

  // Window and lanes
  pixel_t                      win_q [3][3];
  pixel_t                      pass_d;
  res_ctrl_t                   res_d;
  res_ctrl_t                   dly_q [CtrlLat];
  pixel_t                      dly_pass_q [CtrlLat];
  logic [NumChan-1:0][2:0][2:0][ChanW-1:0] lane_win;
  logic [NumChan-1:0][ChanW-1:0]           lane_res;

  // ---------------------------------------------------------------- config
  always_comb begin
    w_raw = {1'b0, cfg_wdata_i[GeomW-1:0]};
    if (w_raw < MinGeomW) begin
      w_raw = MinGeomW;
    end
    if (w_raw > MaxGeomW) begin
      w_raw = MaxGeomW;
    end
    h_raw = cfg_wdata_i[GeomW-1:0];
    if (h_raw < MinGeomH) begin
      h_raw = MinGeomH;
    end
    if (h_raw > MaxGeomH) begin
      h_raw = MaxGeomH;
    end
    eff_w_d = WW'(w_raw);
    eff_h_d = h_raw;
  end

  assign geom_wr = cfg_we_i &&
                   (cfg_addr_i == CFG_WIDTH || cfg_addr_i == CFG_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q <= WW'(ResetW);
      eff_h_q <= GeomW'(ResetHeight);
      coef_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_WIDTH:      eff_w_q   <= eff_w_d;
        CFG_HEIGHT:     eff_h_q   <= eff_h_d;
        CFG_COEF_LEFT:  coef_q[0] <= cfg_wdata_i[CoefW-1:0];
        CFG_COEF_MID:   coef_q[1] <= cfg_wdata_i[CoefW-1:0];
        CFG_COEF_RIGHT: coef_q[2] <= cfg_wdata_i[CoefW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- accept stage
  assign s_axis_tready = (credit_q < CreditW'(OutDepth));
  assign acc_in        = s_axis_tvalid & s_axis_tready;
  assign is_pix        = (s_axis_tuser != CmdFlush);
  assign pop           = m_axis_tvalid & m_axis_tready;

  // Position of the oldest pending pixel
  assign col_last  = (WW'(out_col_q) == eff_w_q - 1'b1);
  assign row_last  = ({1'b0, out_row_q} == eff_h_q - 1'b1);
  assign border    = (out_row_q == '0) || (out_col_q == '0) || row_last || col_last;
  assign pend_full = PB'(eff_w_q) + PB'(1);

  always_comb begin
    emit      = 1'b0;
    pending_d = pending_q;
    s1_d      = '{valid: 1'b0, kind: KIND_CALC, last: col_last & row_last,
                  step: acc_in & is_pix};
    if (acc_in && is_pix) begin
      // Emit once the bottom-right neighbor of the oldest pixel has arrived
      emit      = (pending_q >= pend_full);
      pending_d = emit ? pending_q : pending_q + 1'b1;
      s1_d.kind = border ? KIND_CENTER : KIND_CALC;
    end else if (acc_in) begin
      // Flush drains only border pixels
      emit      = (pending_q != '0) && border;
      pending_d = emit ? pending_q - 1'b1 : pending_q;
      s1_d.kind = KIND_FLUSH;
    end
    s1_d.valid = emit;

    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (emit) begin
      if (col_last) begin
        out_col_d = '0;
        out_row_d = row_last ? '0 : out_row_q + 1'b1;
      end else begin
        out_col_d = out_col_q + 1'b1;
      end
    end

    // A geometry change restarts the frame
    if (geom_wr) begin
      pending_d = '0;
      out_col_d = '0;
      out_row_d = '0;
    end

    // Rows above the new pixel, or the oldest pending pixel on a flush
    raddr_a = is_pix ? wr_ptr_q - AW'(eff_w_q) : wr_ptr_q - AW'(pending_q);
    raddr_b = wr_ptr_q - AW'({eff_w_q, 1'b0});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      wr_ptr_q  <= '0;
      credit_q  <= '0;
      s1_q      <= '0;
    end else begin
      pending_q <= pending_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      if (acc_in && is_pix) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      credit_q  <= credit_q + CreditW'(emit) - CreditW'(pop);
      s1_q      <= s1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_pix_q <= s_axis_tdata;
  end

  rgbc_line_store #(
    .AW (AW)
  ) u_line_store (
    .clk_i     (clk_i),
    .we_i      (acc_in & is_pix),
    .waddr_i   (wr_ptr_q),
    .wdata_i   (s_axis_tdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // ---------------------------------------------------------- window stage
  always_comb begin
    pass_d = (s1_q.kind == KIND_FLUSH) ? rd_a : win_q[2][1];
    res_d  = '{valid: s1_q.valid, calc: (s1_q.kind == KIND_CALC), last: s1_q.last};
  end

  // Shift columns on every stored pixel; new right column from the store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          win_q[c][r] <= '0;
        end
      end
    end else if (s1_q.step) begin
      for (int r = 0; r < 3; r++) begin
        win_q[0][r] <= win_q[1][r];
        win_q[1][r] <= win_q[2][r];
      end
      win_q[2][0] <= rd_b;
      win_q[2][1] <= rd_a;
      win_q[2][2] <= s1_pix_q;
    end
  end

  // Control runs beside the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CtrlLat; i++) begin
        dly_q[i] <= '0;
      end
    end else begin
      dly_q[0] <= res_d;
      for (int i = 1; i < CtrlLat; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dly_pass_q[0] <= pass_d;
    for (int i = 1; i < CtrlLat; i++) begin
      dly_pass_q[i] <= dly_pass_q[i-1];
    end
  end

  // ---------------------------------------------------------------- lanes
  always_comb begin
    for (int l = 0; l < NumChan; l++) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          lane_win[l][c][r] = win_q[c][r][ChanW*l +: ChanW];
        end
      end
    end
  end

  for (genvar l = 0; l < NumChan; l++) begin : g_lane
    rgbc_lane u_lane (
      .clk_i  (clk_i),
      .win_i  (lane_win[l]),
      .coef_i (coef_q),
      .res_o  (lane_res[l])
    );
  end

  // ---------------------------------------------------------------- merge
  rgbc_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (dly_q[CtrlLat-1]),
    .pass_i        (dly_pass_q[CtrlLat-1]),
    .lane_i        (lane_res),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

[hw/rtl/rgbc_port_checker.sv]
// ----------------------------------------------------------------------------
// RGB 3x3 convolution - port checker
// Watches the stream ports of the core: output handshake and result credits.
// ----------------------------------------------------------------------------
`include "rgb_convolution_3x3_core_assert.svh"

module rgbc_port_checker
  import rgbc_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tvalid,
  input logic            s_axis_tready,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [PixW-1:0] m_axis_tdata,
  input logic            m_axis_tlast
);

  // Output handshake
  `RGBC_ASSERT(a_out_valid_holds, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "result withdrawn before taken")
  `RGBC_ASSERT_HOLD(a_out_data_holds, m_axis_tvalid && !m_axis_tready, {m_axis_tlast, m_axis_tdata}, "stalled result changed")

  // Credits: a full buffer frees a slot only when a result is taken
  `RGBC_ASSERT(a_ready_waits_for_pop, (!s_axis_tready && !(m_axis_tvalid && m_axis_tready)) |=> !s_axis_tready, "input ready without a result taken")
  `RGBC_ASSERT(a_pop_frees_slot, (!s_axis_tready && m_axis_tvalid && m_axis_tready) |=> s_axis_tready, "taken result did not free a slot")

  // Nothing is pending right after reset
  `RGBC_ASSERT(a_empty_after_reset, $past(!rst_ni) |-> !m_axis_tvalid, "result present after reset")

endmodule

bind rgb_convolution_3x3_core rgbc_port_checker u_port_checker (.*);
